// ===== hdl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg - wildcard matcher shared definitions
// Sizes, opcodes, wildcard codes, the case fold and the cell control types.
// ----------------------------------------------------------------------------
package wgm_pkg;

  // Pattern store depth and the width of a length that can reach it
  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  // Broadcast to every cell
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       text;
    logic       start;
    logic       case_sens;
    logic [7:0] pat_byte;
    logic [7:0] text_byte;   // already folded
  } cell_ctrl_t;

  // Handed from one cell to the next
  typedef struct packed {
    logic link;       // next vector bit arriving at this position
    logic lead_set;   // star prefix grows into this position
  } chain_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  // a-z to A-Z unless case sensitive
  function automatic logic [7:0] fold(input logic [7:0] b, input logic case_sens);
    logic [7:0] r;
    r = b;
    if (!case_sens && (b inside {[8'h61 : 8'h7A]})) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/wgm_if.sv =====
// ----------------------------------------------------------------------------
// wgm_if - wildcard matcher channel interfaces
// Command, result and configuration channels, valid/ready each.
// ----------------------------------------------------------------------------
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       text_start;
  logic       text_end;

  modport source (output valid, opcode, data_byte, text_start, text_end, input ready);
  modport sink   (input valid, opcode, data_byte, text_start, text_end, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

interface wgm_cfg_if;
  logic valid;
  logic ready;
  logic case_sensitive;

  modport source (output valid, case_sensitive, input ready);
  modport sink   (input valid, case_sensitive, output ready);
endinterface

// ===== hdl/wildcard_glob_match_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_match_top - streaming wildcard pattern matcher
// Pattern held in a row of cells; text bytes advance a reachable-position
// vector one byte per cycle while cmd.ready is high; '*' and '?' as glob wildcards.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                       item
//  -------  ---  -------------------------------------------  ----------------
//  cmd      in   opcode, data_byte, text_start, text_end      command / byte
//  res      out  matched, pattern_overflow                    match verdict
//  cfg      in   case_sensitive                               mode write
//
//  One command item per cycle, every opcode, while cmd.ready is high. A
//  verdict is written into the result register, or into its skid stage
//  when the result register is still held. The row of cells updates all
//  positions together; star closure ripples along the row like a carry
//  chain, which sets the clock path. cmd.ready drops only when the result
//  register and its skid stage both hold an item. cfg is always ready.
//  rst is synchronous: empty pattern, empty vector, no overflow, folding on.
//
module wildcard_glob_match_top (
  input  logic      clk,
  input  logic      rst,
  wgm_in_if.sink    cmd,
  wgm_out_if.source res,
  wgm_cfg_if.sink   cfg
);

  localparam int N = wgm_pkg::MAX_PATTERN;
  localparam int W = wgm_pkg::LEN_W;

  logic [W-1:0]        length;
  logic                ovf;
  logic                case_sens;
  logic                lead_tail;     // star-prefix bit at position N

  logic                fire;
  logic                buf_full;
  logic                store_full;
  logic                push;
  wgm_pkg::result_t    push_data;
  wgm_pkg::cell_ctrl_t ctrl;

  logic [N-1:0]        active;
  logic [N-1:0]        wsel;
  wgm_pkg::chain_t     chain [N+1];
  logic [N:0]          closed_vec;
  logic [N:0]          lead_vec;

  // configuration: one register, taken whenever offered
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_sens <= 1'b0;
    end else if (cfg.valid) begin
      case_sens <= cfg.case_sensitive;
    end
  end

  assign cmd.ready  = !buf_full;
  assign fire       = cmd.valid && cmd.ready;
  assign store_full = (length == W'(N));

  // broadcast to the row
  always_comb begin
    ctrl           = '0;
    ctrl.case_sens = case_sens;
    ctrl.pat_byte  = cmd.data_byte;
    ctrl.text_byte = wgm_pkg::fold(cmd.data_byte, case_sens);
    ctrl.start     = cmd.text_start;
    if (fire) begin
      case (cmd.opcode)
        wgm_pkg::OP_CLEAR:  ctrl.clear  = 1'b1;
        wgm_pkg::OP_APPEND: ctrl.append = !store_full;
        wgm_pkg::OP_TEXT:   ctrl.text   = 1'b1;
        default:            ctrl.clear  = 1'b0;
      endcase
    end
  end

  // length, overflow and the tail position past the last cell
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      length     <= '0;
      ovf        <= 1'b0;
      lead_tail  <= 1'b0;
    end else begin
      if (fire && (cmd.opcode == wgm_pkg::OP_APPEND)) begin
        if (store_full) begin
          ovf <= 1'b1;
        end else begin
          length <= length + W'(1);
        end
      end
      lead_tail <= lead_tail || chain[N].lead_set;
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign active[i] = (W'(i) < length);
    assign wsel[i]   = (W'(i) == length);

    wgm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .active    (active[i]),
      .wsel      (wsel[i]),
      .lead_seed (i == 0),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .closed    (closed_vec[i]),
      .lead      (lead_vec[i])
    );
  end

  assign closed_vec[N] = chain[N].link;
  assign lead_vec[N]   = lead_tail;

  // verdict: bit at the pattern length, forced low on overflow
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    push_data.pattern_overflow = ovf;
    if (fire) begin
      case (cmd.opcode)
        wgm_pkg::OP_TEXT: begin
          push              = cmd.text_end;
          push_data.matched = closed_vec[length] && !ovf;
        end
        wgm_pkg::OP_QUERY: begin
          push              = 1'b1;
          push_data.matched = lead_vec[length] && !ovf;
        end
        default: push = 1'b0;
      endcase
    end
  end

  wgm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .res       (res)
  );

endmodule

// ===== hdl/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell - one pattern position
// Holds a pattern byte, its reachable bit and its star-prefix bit.
// ----------------------------------------------------------------------------
module wgm_cell (
  input  logic                clk,
  input  logic                rst,
  input  wgm_pkg::cell_ctrl_t ctrl,
  input  logic                active,     // position below pattern length
  input  logic                wsel,       // position equals pattern length
  input  logic                lead_seed,  // star-prefix value after clear
  input  wgm_pkg::chain_t     chain_in,
  output wgm_pkg::chain_t     chain_out,
  output logic                closed,     // next vector bit, stars closed
  output logic                lead
);

  logic [7:0] pat;
  logic       reach;
  logic       is_star;
  logic       is_qmark;
  logic       v;
  logic       stay;
  logic       step;

  always_ff @(posedge clk) begin
    if (ctrl.append && wsel) begin
      pat <= ctrl.pat_byte;
    end
  end

  assign is_star  = (pat == wgm_pkg::STAR_BYTE);
  assign is_qmark = (pat == wgm_pkg::QMARK_BYTE);
  assign v        = ctrl.start ? lead : reach;

  // star keeps its position, anything else moves one on when it matches
  assign stay = active && v && is_star;
  assign step = active && v && !is_star &&
                (is_qmark || (wgm_pkg::fold(pat, ctrl.case_sens) == ctrl.text_byte));

  assign closed             = stay || chain_in.link;
  assign chain_out.link     = step || (closed && active && is_star);
  assign chain_out.lead_set = ctrl.append && wsel && lead &&
                              (ctrl.pat_byte == wgm_pkg::STAR_BYTE);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      reach <= 1'b0;
      lead  <= lead_seed;
    end else begin
      if (ctrl.text) begin
        reach <= closed;
      end
      lead <= lead || chain_in.lead_set;
    end
  end

endmodule

// ===== hdl/wgm_out_buf.sv =====
// ----------------------------------------------------------------------------
// wgm_out_buf - result register with skid stage
// Two-entry buffer; full only when both entries hold an item.
// ----------------------------------------------------------------------------
module wgm_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wgm_pkg::result_t   push_data,
  output logic               full,
  wgm_out_if.source          res
);

  logic             out_valid;
  logic             skid_valid;
  wgm_pkg::result_t out_data;
  wgm_pkg::result_t skid_data;
  logic             pop;

  assign pop  = out_valid && res.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (push) begin
      skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid            = out_valid;
  assign res.matched          = out_data.matched;
  assign res.pattern_overflow = out_data.pattern_overflow;

endmodule

// ===== hdl/wgm_checker.sv =====
// ----------------------------------------------------------------------------
// wgm_checker - port-level checks for the wildcard matcher
// Watches the top level's channels; bound to the top level below.
// ----------------------------------------------------------------------------
module wgm_checker (
  input logic clk,
  input logic rst,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_matched,
  input logic res_overflow
);

  // an overflowed pattern never reports a match
  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_overflow |-> !res_matched)
    else $error("match reported with pattern overflow");

  // commands stall only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid)
    else $error("cmd stalled with no result waiting");

  // out of reset: nothing pending, commands welcome
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid && cmd_ready)
    else $error("buffer not empty after reset");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_matched) &&
                                 $stable(res_overflow))
    else $error("result changed while stalled");

endmodule

bind wildcard_glob_match_top wgm_checker u_wgm_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_matched  (res.matched),
  .res_overflow (res.pattern_overflow)
);

// ===== bench/wildcard_glob_match_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_match_top_tb - self-checking bench for the wildcard matcher
// Loads patterns and streams texts through the command channel. A predictor
// tracks the reachable-position vector and queues the verdict each text end
// or empty-text query should give. The predictor is checked field by field
// against every result item, with random idling on both channels.
// ----------------------------------------------------------------------------
module wildcard_glob_match_top_tb;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 4;     // verdict register plus skid stage
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS   = 360;
  localparam int IDX_W         = $clog2(wgm_pkg::MAX_PATTERN);

  // nothing consumed yet
  localparam logic [wgm_pkg::MAX_PATTERN:0] ORIGIN = (wgm_pkg::MAX_PATTERN + 1)'(1);

  // --------------------------------------------------------------------------
  // Predictor: own copy of the pattern, the position vector, the overflow
  // flag and the case mode; verdicts waiting for the block in arrival order.
  // --------------------------------------------------------------------------
  class glob_match_board;
    logic [7:0]                    pat_mem [wgm_pkg::MAX_PATTERN];
    logic [wgm_pkg::LEN_W-1:0]     pat_len;
    logic [wgm_pkg::MAX_PATTERN:0] live;
    logic                          ovf;
    logic                          case_sens;
    wgm_pkg::result_t              verdicts_due [$];
    int unsigned                   errors;

    function new();
      pat_len   = '0;
      live      = '0;
      ovf       = 1'b0;
      case_sens = 1'b0;
      errors    = 0;
    endfunction

    function logic [7:0] upcase(logic [7:0] b);
      if (!case_sens && b >= 8'h61 && b <= 8'h7A) begin
        return b - 8'h20;
      end
      return b;
    endfunction

    // a star reached at i also reaches i+1; ascending order lets runs chain
    function logic [wgm_pkg::MAX_PATTERN:0] star_close(logic [wgm_pkg::MAX_PATTERN:0] v);
      for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
        if (i < pat_len && v[i] && pat_mem[i] == wgm_pkg::STAR_BYTE) begin
          v[i+1] = 1'b1;
        end
      end
      return v;
    endfunction

    function logic [wgm_pkg::MAX_PATTERN:0] step_byte(logic [wgm_pkg::MAX_PATTERN:0] v,
                                                      logic [7:0] ch);
      logic [wgm_pkg::MAX_PATTERN:0] nv;
      logic [7:0]                    c;
      nv = '0;
      c  = upcase(ch);
      for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
        if (i < pat_len && v[i]) begin
          if (pat_mem[i] == wgm_pkg::STAR_BYTE) begin
            nv[i] = 1'b1;
          end else if (pat_mem[i] == wgm_pkg::QMARK_BYTE || upcase(pat_mem[i]) == c) begin
            nv[i+1] = 1'b1;
          end
        end
      end
      return star_close(nv);
    endfunction

    function void push_verdict(logic [wgm_pkg::MAX_PATTERN:0] v);
      wgm_pkg::result_t r;
      r.matched          = v[pat_len] & ~ovf;
      r.pattern_overflow = ovf;
      verdicts_due = {verdicts_due, r};
    endfunction

    function void take_command(wgm_pkg::opcode_t op, logic [7:0] data, logic first,
                               logic last);
      case (op)
        wgm_pkg::OP_CLEAR: begin
          pat_len = '0;
          live    = '0;
          ovf     = 1'b0;
        end
        wgm_pkg::OP_APPEND: begin
          if (pat_len < wgm_pkg::MAX_PATTERN) begin
            pat_mem[pat_len[IDX_W-1:0]] = data;
            pat_len++;
          end else begin
            ovf = 1'b1;
          end
        end
        wgm_pkg::OP_TEXT: begin
          live = step_byte(first ? star_close(ORIGIN) : live, data);
          if (last) begin
            push_verdict(live);
          end
        end
        default: begin
          push_verdict(star_close(ORIGIN));
        end
      endcase
    endfunction

    function void check_verdict(logic m, logic o);
      wgm_pkg::result_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: expected nothing, got matched %0b overflow %0b",
                 $time, m, o);
        return;
      end
      want = verdicts_due.pop_front();
      if (m !== want.matched) begin
        errors++;
        $display("%0t: matched expected %0b got %0b", $time, want.matched, m);
      end
      if (o !== want.pattern_overflow) begin
        errors++;
        $display("%0t: pattern_overflow expected %0b got %0b", $time, want.pattern_overflow, o);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always #HALF_PERIOD clk = ~clk;

  wgm_in_if  cmd ();
  wgm_out_if res ();
  wgm_cfg_if cfg ();

  wildcard_glob_match_top DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg)
  );

  glob_match_board sb;
  int src_idle_pct;    // chance in 100 of a sender gap before each item
  int sink_stall_pct;  // chance in 100 the result side holds ready low
  int items_sent;

  // Result side back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    res.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Both channels observed at the rising edge, before the block's own updates
  // land. A verdict is registered before it reaches the result channel, so the
  // two checks here never depend on each other within one edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        sb.check_verdict(res.matched, res.pattern_overflow);
      end
      if (cmd.valid && cmd.ready) begin
        sb.take_command(wgm_pkg::opcode_t'(cmd.opcode), cmd.data_byte, cmd.text_start,
                        cmd.text_end);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; a command item is held
  // until the rising edge that takes it. valid stays high across back-to-back
  // items and is only dropped by a gap or by cmd_idle.
  // --------------------------------------------------------------------------
  task automatic push_cmd(wgm_pkg::opcode_t op, logic [7:0] data, logic first, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      cmd.valid = 1'b0;
    end
    @(negedge clk);
    cmd.valid      = 1'b1;
    cmd.opcode     = op;
    cmd.data_byte  = data;
    cmd.text_start = first;
    cmd.text_end   = last;
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  task automatic cmd_idle();
    @(negedge clk);
    cmd.valid = 1'b0;
  endtask

  // Sender holds off until every verdict owed has come back
  task automatic drain();
    cmd_idle();
    while (sb.verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Mode writes only with the block idle. Clears, appends and mid-text bytes
  // owe no verdict, so let the pipeline settle before touching the mode.
  task automatic set_case(logic cs);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg.valid          = 1'b1;
    cfg.case_sensitive = cs;
    do @(posedge clk); while (!cfg.ready);
    sb.case_sens = cs;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  localparam logic [7:0] LETTERS [4] = '{8'h61, 8'h62, 8'h41, 8'h42};

  function automatic logic [7:0] pick_pat_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return wgm_pkg::STAR_BYTE;
    if (r < 50) return wgm_pkg::QMARK_BYTE;
    if (r < 85) return LETTERS[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  // Mostly a tiny alphabet so literals actually line up; wildcard bytes in
  // the text are plain literals
  function automatic logic [7:0] pick_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return LETTERS[$urandom_range(3)];
    if (r < 75) return $urandom_range(1) ? wgm_pkg::STAR_BYTE : wgm_pkg::QMARK_BYTE;
    return 8'($urandom);
  endfunction

  // Stream one text; now and then with broken framing or an append wedged in
  task automatic send_text(logic [7:0] txt [$]);
    logic chop;
    logic first, last;
    chop = ($urandom_range(99) < 8);
    for (int i = 0; i < txt.size(); i++) begin
      first = (i == 0);
      last  = (i == txt.size() - 1);
      if (chop) begin
        first = 1'($urandom);
        last  = 1'($urandom);
      end
      if (i > 0 && $urandom_range(99) < 3) begin
        push_cmd(wgm_pkg::OP_APPEND, pick_pat_byte(), 1'($urandom), 1'($urandom));
      end
      push_cmd(wgm_pkg::OP_TEXT, txt[i], first, last);
    end
  endtask

  task automatic run_sequence();
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    logic [7:0] b;
    int         plen;
    int         r;

    r = $urandom_range(99);
    // noise: anything goes, unused fields included
    if (r < 10) begin
      repeat ($urandom_range(6, 1)) begin
        push_cmd(wgm_pkg::opcode_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
                 1'($urandom));
      end
      return;
    end

    // short patterns mostly; a few long enough to overflow the store
    r = $urandom_range(99);
    if (r < 78) plen = $urandom_range(8);
    else if (r < 92) plen = $urandom_range(32, 9);
    else plen = $urandom_range(40, 30);

    push_cmd(wgm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int k = 0; k < plen; k++) begin
      b = pick_pat_byte();
      pat = {pat, b};
      push_cmd(wgm_pkg::OP_APPEND, b, 1'($urandom), 1'($urandom));
    end

    repeat ($urandom_range(4, 1)) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_cmd(wgm_pkg::OP_QUERY, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        txt.delete();
        if (r < 60) begin
          // built to fit the pattern, letters case-flipped at random
          foreach (pat[k]) begin
            if (pat[k] == wgm_pkg::STAR_BYTE) begin
              repeat ($urandom_range(3)) txt = {txt, pick_text_char()};
            end else if (pat[k] == wgm_pkg::QMARK_BYTE) begin
              txt = {txt, pick_text_char()};
            end else if (((pat[k] | 8'h20) inside {[8'h61 : 8'h7A]}) && $urandom_range(1)) begin
              txt = {txt, pat[k] ^ 8'h20};
            end else begin
              txt = {txt, pat[k]};
            end
          end
          // near miss
          if (txt.size() != 0 && $urandom_range(3) == 0) begin
            txt[$urandom_range(txt.size() - 1)] = pick_text_char();
          end
        end else begin
          repeat ($urandom_range(12, 1)) txt = {txt, pick_text_char()};
        end
        if (txt.size() == 0) begin
          txt = {txt, pick_text_char()};
        end
        send_text(txt);
      end
    end

    if ($urandom_range(29) == 0) begin
      drain();
    end
  endtask

  // Extremes of the fields, every opcode and the awkward corners
  task automatic run_directed();
    push_cmd(wgm_pkg::OP_QUERY,  8'h00,               1'b0, 1'b0);  // empty, empty: hit
    push_cmd(wgm_pkg::OP_TEXT,   8'h61,               1'b0, 1'b1);  // no start: miss
    push_cmd(wgm_pkg::OP_CLEAR,  8'hFF,               1'b1, 1'b1);  // unused fields high
    push_cmd(wgm_pkg::OP_APPEND, wgm_pkg::STAR_BYTE,  1'b1, 1'b1);
    push_cmd(wgm_pkg::OP_QUERY,  8'hFF,               1'b1, 1'b1);  // all-star: hit
    push_cmd(wgm_pkg::OP_APPEND, 8'h61,               1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_APPEND, wgm_pkg::QMARK_BYTE, 1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_QUERY,  8'h00,               1'b0, 1'b0);  // "*a?" needs two
    push_cmd(wgm_pkg::OP_TEXT,   8'h78,               1'b1, 1'b0);
    push_cmd(wgm_pkg::OP_TEXT,   8'h41,               1'b0, 1'b0);  // 'A' folds onto 'a'
    push_cmd(wgm_pkg::OP_TEXT,   8'h62,               1'b0, 1'b1);
    push_cmd(wgm_pkg::OP_TEXT,   8'h00,               1'b1, 1'b1);  // one-byte text
    push_cmd(wgm_pkg::OP_TEXT,   8'h61,               1'b0, 1'b0);  // carries on
    push_cmd(wgm_pkg::OP_TEXT,   8'h7A,               1'b0, 1'b1);
    push_cmd(wgm_pkg::OP_APPEND, 8'h62,               1'b0, 1'b0);  // grows mid-text
    push_cmd(wgm_pkg::OP_TEXT,   8'h62,               1'b0, 1'b1);
    push_cmd(wgm_pkg::OP_CLEAR,  8'h00,               1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_APPEND, 8'h00,               1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_TEXT,   8'h00,               1'b1, 1'b1);  // zero is a literal
    push_cmd(wgm_pkg::OP_TEXT,   8'hFF,               1'b1, 1'b1);
    push_cmd(wgm_pkg::OP_CLEAR,  8'h00,               1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_APPEND, wgm_pkg::QMARK_BYTE, 1'b0, 1'b0);
    push_cmd(wgm_pkg::OP_TEXT,   8'hFF,               1'b1, 1'b1);
    push_cmd(wgm_pkg::OP_QUERY,  8'h00,               1'b0, 1'b0);
  endtask

  task automatic run_phase(int src_pct, int sink_pct, logic cs);
    set_case(cs);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    items_sent     = 0;
    while (items_sent < PHASE_ITEMS) begin
      run_sequence();
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Run: reset once, directed items with folding on, then four random phases
  // that flip the case mode and walk through the idling mixes.
  // --------------------------------------------------------------------------
  initial begin
    sb                 = new();
    rst                = 1'b1;
    cmd.valid          = 1'b0;
    cmd.opcode         = wgm_pkg::OP_CLEAR;
    cmd.data_byte      = 8'h00;
    cmd.text_start     = 1'b0;
    cmd.text_end       = 1'b0;
    cfg.valid          = 1'b0;
    cfg.case_sensitive = 1'b0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    items_sent         = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_case(1'b0);
    run_directed();

    run_phase(0,  0,  1'b1);   // flat out
    run_phase(78, 0,  1'b0);   // sparse sender
    run_phase(0,  78, 1'b1);   // stalling receiver
    run_phase(16, 16, 1'b0);   // light idling both sides

    // drain() in the last phase has emptied the queue; catch any stragglers
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
